// File: hdl/cube_chunk_neighbor_assert.svh
// cube_chunk_neighbor_assert.svh: assertion macros for the chunk neighbor block
`ifndef CUBE_CHUNK_NEIGHBOR_ASSERT_SVH
`define CUBE_CHUNK_NEIGHBOR_ASSERT_SVH

`ifndef SYNTHESIS

// Implication checked at every rising clock edge, off while reset is held.
`define CCN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same check, also active during reset.
`define CCN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define CCN_ASSERT(lbl, prop, msg)
`define CCN_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hdl/ccn_pkg.sv
// ----------------------------------------------------------------------------
// ccn_pkg: types and constants for the cubed-sphere chunk neighbor block
// Face bases, seam mapping function and the transaction payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ccn_pkg;

    localparam int IDX_W  = 20;          // cell index width
    localparam int LAST_W = IDX_W + 1;   // span-1 clipped to this width
    localparam int NUM_FACES = 6;

    typedef enum logic [1:0] {
        DIR_MINUS_U = 2'd0,
        DIR_PLUS_U  = 2'd1,
        DIR_MINUS_V = 2'd2,
        DIR_PLUS_V  = 2'd3
    } t_dir;

    // Index selection on the far side of a seam
    typedef enum logic [1:0] {
        SEL_LAST   = 2'd0,
        SEL_ZERO   = 2'd1,
        SEL_MIRROR = 2'd2,
        SEL_KEEP   = 2'd3
    } t_sel;

    typedef struct packed {
        logic [2:0] nb_face;
        t_sel       col_sel;
        t_sel       row_sel;
    } t_seam;

    typedef struct packed {
        logic [2:0]       face;
        logic [4:0]       level;
        logic [IDX_W-1:0] cell_col;
        logic [IDX_W-1:0] cell_row;
        logic [1:0]       direction;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [2:0]       nb_face;
        logic [IDX_W-1:0] nb_col;
        logic [IDX_W-1:0] nb_row;
    } t_out_item;

    // Face bases: normal, right, up
    localparam int FACE_NRM [NUM_FACES][3] = '{
        '{ 1, 0, 0}, '{-1, 0, 0}, '{0,  1, 0}, '{0, -1, 0}, '{0, 0,  1}, '{0, 0, -1}
    };
    localparam int FACE_RGT [NUM_FACES][3] = '{
        '{ 0, 0,-1}, '{ 0, 0, 1}, '{1,  0, 0}, '{1,  0, 0}, '{1, 0,  0}, '{-1, 0, 0}
    };
    localparam int FACE_UPV [NUM_FACES][3] = '{
        '{ 0, 1, 0}, '{ 0, 1, 0}, '{0,  0, 1}, '{0,  0,-1}, '{0, 1,  0}, '{ 0, 1, 0}
    };

    function automatic t_sel seam_sel(input int across, input int along);
        t_sel s;
        if (across > 0)      s = SEL_LAST;
        else if (across < 0) s = SEL_ZERO;
        else if (along < 0)  s = SEL_MIRROR;
        else                 s = SEL_KEEP;
        return s;
    endfunction

    // Seam mapping for a face and edge; a 24-entry table after synthesis.
    function automatic t_seam seam_map(input logic [2:0] face, input t_dir dir);
        t_seam res;
        int    f;
        int    nf;
        int    sgn;
        int    d;
        int    base [3];
        int    tang [3];
        int    dnr;
        int    dtr;
        int    dnu;
        int    dtu;
        logic  hit;
        res = '{nb_face: 3'd0, col_sel: SEL_ZERO, row_sel: SEL_ZERO};
        if (face < 3'(NUM_FACES)) begin
            f = int'(face);
            for (int k = 0; k < 3; k++) begin
                if (dir == DIR_MINUS_U || dir == DIR_PLUS_U) begin
                    base[k] = FACE_RGT[f][k];
                    tang[k] = FACE_UPV[f][k];
                end else begin
                    base[k] = FACE_UPV[f][k];
                    tang[k] = FACE_RGT[f][k];
                end
            end
            sgn = (dir == DIR_PLUS_U || dir == DIR_PLUS_V) ? 1 : -1;
            nf  = 0;
            hit = 1'b0;
            for (int g = 0; g < NUM_FACES; g++) begin
                d = 0;
                for (int k = 0; k < 3; k++) d += FACE_NRM[g][k] * sgn * base[k];
                if (!hit && d > 0) begin
                    nf  = g;
                    hit = 1'b1;
                end
            end
            dnr = 0; dtr = 0; dnu = 0; dtu = 0;
            for (int k = 0; k < 3; k++) begin
                dnr += FACE_NRM[f][k] * FACE_RGT[nf][k];
                dtr += tang[k] * FACE_RGT[nf][k];
                dnu += FACE_NRM[f][k] * FACE_UPV[nf][k];
                dtu += tang[k] * FACE_UPV[nf][k];
            end
            res.nb_face = 3'(nf);
            res.col_sel = seam_sel(dnr, dtr);
            res.row_sel = seam_sel(dnu, dtu);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hdl/cube_chunk_neighbor.sv
// ----------------------------------------------------------------------------
// cube_chunk_neighbor: edge neighbor of a chunk on a six-face cubed sphere
// Interior steps move column or row by one; seam steps use the face table.
// ----------------------------------------------------------------------------
//  channel | direction | valid       | ready       | payload
//  --------+-----------+-------------+-------------+-----------
//  in      | to block  | i_in_valid  | o_in_ready  | i_in
//  out     | from block| o_out_valid | i_out_ready | o_out
//
// One transaction per cycle while the receiver keeps up; an input register
// and a result register with the neighbor mapping in between.
// Synchronous active-low reset empties both registers.
// A stalled result holds in the result register while the input register
// still takes one more transaction; back-pressure reaches o_in_ready
// combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cube_chunk_neighbor_assert.svh"

module cube_chunk_neighbor
    import ccn_pkg::*;
#(
    parameter int MAX_LEVEL = 20
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out
);

    logic      r_in_vld, n_in_vld;
    t_in_item  r_in;
    logic      r_out_vld, n_out_vld;
    t_out_item r_out, n_out;

    logic              out_en;
    logic              bad;
    logic [LAST_W-1:0] last;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  col_s, row_s, along, mirror;
    t_dir              dir;
    t_seam             seam;

    assign out_en     = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || out_en;

    // span-1 clipped: all ones when the grid is wider than the index field
    always_comb begin
        if (r_in.level >= 5'(LAST_W))
            last = '1;
        else
            last = (LAST_W'(1) << r_in.level) - LAST_W'(1);
    end
    assign last_idx = last[IDX_W-1:0];

    assign bad = (r_in.face >= 3'(NUM_FACES)) || (int'(r_in.level) > MAX_LEVEL);
    assign dir = t_dir'(r_in.direction);

    assign col_s  = ({1'b0, r_in.cell_col} > last) ? last_idx : r_in.cell_col;
    assign row_s  = ({1'b0, r_in.cell_row} > last) ? last_idx : r_in.cell_row;
    assign along  = (dir == DIR_MINUS_U || dir == DIR_PLUS_U) ? row_s : col_s;
    assign mirror = last_idx - along;
    assign seam   = seam_map(r_in.face, dir);

    function automatic logic [IDX_W-1:0] pick(input t_sel sel,
                                              input logic [IDX_W-1:0] lst,
                                              input logic [IDX_W-1:0] mir,
                                              input logic [IDX_W-1:0] keep);
        logic [IDX_W-1:0] v;
        unique case (sel)
            SEL_LAST:   v = lst;
            SEL_ZERO:   v = '0;
            SEL_MIRROR: v = mir;
            SEL_KEEP:   v = keep;
            default:    v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        n_out = '0;
        if (!bad) begin
            n_out.found   = 1'b1;
            n_out.nb_face = r_in.face;
            n_out.nb_col  = col_s;
            n_out.nb_row  = row_s;
            priority if (dir == DIR_MINUS_U && col_s != '0) begin
                n_out.nb_col = col_s - IDX_W'(1);
            end else if (dir == DIR_PLUS_U && {1'b0, col_s} < last) begin
                n_out.nb_col = col_s + IDX_W'(1);
            end else if (dir == DIR_MINUS_V && row_s != '0) begin
                n_out.nb_row = row_s - IDX_W'(1);
            end else if (dir == DIR_PLUS_V && {1'b0, row_s} < last) begin
                n_out.nb_row = row_s + IDX_W'(1);
            end else begin
                n_out.nb_face = seam.nb_face;
                n_out.nb_col  = pick(seam.col_sel, last_idx, mirror, along);
                n_out.nb_row  = pick(seam.row_sel, last_idx, mirror, along);
            end
        end
    end

    assign n_in_vld  = o_in_ready ? i_in_valid : r_in_vld;
    assign n_out_vld = out_en ? r_in_vld : r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) r_in <= i_in;
        if (out_en)     r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    `CCN_ASSERT(a_in_capture, i_in_valid && o_in_ready |=> r_in_vld, "accepted transaction lost at input register")
    `CCN_ASSERT(a_bad_face, r_in_vld && out_en && r_in.face >= 3'(NUM_FACES) |=> o_out_valid && !o_out.found, "invalid face produced a neighbor")
    `CCN_ASSERT(a_face_range, o_out_valid && o_out.found |-> o_out.nb_face < 3'(NUM_FACES), "neighbor face out of range")
    `CCN_ASSERT(a_no_drop, r_in_vld && !out_en |=> r_in_vld && $stable(r_in), "input register overwritten while stalled")
    `CCN_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid right after reset")

endmodule

`default_nettype wire

// File: tb/ccn_tb_pkg.sv
// ----------------------------------------------------------------------------
// ccn_tb_pkg: neighbor predictor and result scoreboard for cube_chunk_neighbor
// Integer model of the cubed-sphere edge step, plus a queue of the neighbor
// keys still owed by the block, checked field by field as results arrive.
// ----------------------------------------------------------------------------
package ccn_tb_pkg;
    import ccn_pkg::*;

    localparam int MAX_DEPTH = 20;
    localparam int FACES     = 6;

    // Face frames: outward normal, right axis, up axis
    localparam int SURF_NORMAL [FACES][3] = '{
        '{ 1, 0, 0}, '{-1, 0, 0}, '{0,  1, 0}, '{0, -1, 0}, '{0, 0,  1}, '{0, 0, -1}
    };
    localparam int SURF_RIGHT [FACES][3] = '{
        '{ 0, 0,-1}, '{ 0, 0, 1}, '{1,  0, 0}, '{1,  0, 0}, '{1, 0,  0}, '{-1, 0, 0}
    };
    localparam int SURF_UP [FACES][3] = '{
        '{ 0, 1, 0}, '{ 0, 1, 0}, '{0,  0, 1}, '{0,  0,-1}, '{0, 1,  0}, '{ 0, 1, 0}
    };

    // Index on the far face along one axis: pinned at an end when the axis
    // runs across the seam, else carried over, mirrored if reversed.
    function automatic logic [IDX_W-1:0] seam_pick(input int across, input int along,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [IDX_W-1:0] last);
        logic [IDX_W-1:0] v;
        if (across > 0)      v = last;
        else if (across < 0) v = '0;
        else if (along < 0)  v = last - idx;
        else                 v = idx;
        return v;
    endfunction

    function automatic t_out_item predict_neighbor(input t_in_item it);
        t_out_item        res;
        logic [IDX_W-1:0] last;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] along;
        int               f;
        int               nf;
        int               sgn;
        int               d;
        int               n_r;
        int               t_r;
        int               n_u;
        int               t_u;
        int               edge_ax [3];
        int               tang [3];
        bit               horiz;
        bit               hit;
        res = '0;
        if (it.face > 3'(FACES - 1) || it.level > 5'(MAX_DEPTH)) return res;

        last = IDX_W'((21'd1 << it.level) - 21'd1);
        col  = (it.cell_col > last) ? last : it.cell_col;
        row  = (it.cell_row > last) ? last : it.cell_row;
        res.found   = 1'b1;
        res.nb_face = it.face;

        if (it.direction == DIR_MINUS_U && col != '0)        col = col - 1'b1;
        else if (it.direction == DIR_PLUS_U && col != last)  col = col + 1'b1;
        else if (it.direction == DIR_MINUS_V && row != '0)   row = row - 1'b1;
        else if (it.direction == DIR_PLUS_V && row != last)  row = row + 1'b1;
        else begin
            f     = int'(it.face);
            horiz = (it.direction == DIR_MINUS_U || it.direction == DIR_PLUS_U);
            sgn   = (it.direction == DIR_PLUS_U || it.direction == DIR_PLUS_V) ? 1 : -1;
            along = horiz ? row : col;
            for (int k = 0; k < 3; k++) begin
                edge_ax[k] = sgn * (horiz ? SURF_RIGHT[f][k] : SURF_UP[f][k]);
                tang[k]    = horiz ? SURF_UP[f][k] : SURF_RIGHT[f][k];
            end
            // new face: first one whose normal points along the edge
            nf  = 0;
            hit = 1'b0;
            for (int g = 0; g < FACES; g++) begin
                d = 0;
                for (int k = 0; k < 3; k++) d += SURF_NORMAL[g][k] * edge_ax[k];
                if (!hit && d > 0) begin
                    nf  = g;
                    hit = 1'b1;
                end
            end
            n_r = 0; t_r = 0; n_u = 0; t_u = 0;
            for (int k = 0; k < 3; k++) begin
                n_r += SURF_NORMAL[f][k] * SURF_RIGHT[nf][k];
                t_r += tang[k] * SURF_RIGHT[nf][k];
                n_u += SURF_NORMAL[f][k] * SURF_UP[nf][k];
                t_u += tang[k] * SURF_UP[nf][k];
            end
            col = seam_pick(n_r, t_r, along, last);
            row = seam_pick(n_u, t_u, along, last);
            res.nb_face = 3'(nf);
        end
        res.nb_col = col;
        res.nb_row = row;
        return res;
    endfunction

    class NeighborScoreboard;
        t_out_item expected_q[$];
        int        errors   = 0;
        int        reported = 0;

        function void note_input(input t_in_item it);
            expected_q.push_back(predict_neighbor(it));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report(input string what, input t_out_item exp, input t_out_item got);
            if (reported < 10)
                $display("%s: exp found=%0d face=%0d col=%0h row=%0h | got found=%0d face=%0d col=%0h row=%0h",
                         what, exp.found, exp.nb_face, exp.nb_col, exp.nb_row,
                         got.found, got.nb_face, got.nb_col, got.nb_row);
            reported++;
        endfunction

        function void check_result(input t_out_item got);
            t_out_item exp;
            if (expected_q.size() == 0) begin
                errors++;
                report("result with no transaction pending", '0, got);
                return;
            end
            exp = expected_q.pop_front();
            if (got.found !== exp.found || got.nb_face !== exp.nb_face ||
                got.nb_col !== exp.nb_col || got.nb_row !== exp.nb_row) begin
                errors++;
                report("neighbor mismatch", exp, got);
            end
        endfunction
    endclass

endpackage

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and checking for cube_chunk_neighbor
// Directed seam, clamp and reject cases, then bursts of random chunk keys
// against a stalling receiver; every result is matched against the predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import ccn_pkg::*;
    import ccn_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_EVERY  = 450;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in        = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out;

    NeighborScoreboard sb;
    int cycles = 0;

    always #2 i_clk = ~i_clk;

    cube_chunk_neighbor #(
        .MAX_LEVEL  (MAX_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Transaction monitor and watchdog; all sampled values are pre-edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_input(i_in);
            if (o_out_valid && i_out_ready) sb.check_result(o_out);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL cube_chunk_neighbor");
            $finish;
        end
    end

    // Receiver: long free-running stretches mixed with short ready/stall runs
    int  rx_run  = 0;
    bit  rx_rdy  = 1'b0;
    always @(posedge i_clk) begin
        if (rx_run == 0) begin
            if ($urandom_range(0, 5) == 0) begin
                rx_rdy = 1'b1;
                rx_run = $urandom_range(50, 300);
            end else if (rx_rdy) begin
                rx_rdy = 1'b0;
                rx_run = $urandom_range(1, 6);
            end else begin
                rx_rdy = 1'b1;
                rx_run = $urandom_range(1, 12);
            end
        end else begin
            rx_run--;
        end
        i_out_ready <= rx_rdy;
    end

    function automatic t_in_item mk_item(input int face, input int level, input int col,
                                         input int row, input t_dir dir);
        t_in_item it;
        it.face      = 3'(face);
        it.level     = 5'(level);
        it.cell_col  = IDX_W'(col);
        it.cell_row  = IDX_W'(row);
        it.direction = dir;
        return it;
    endfunction

    // Seam-heavy index choice below span
    function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] last);
        logic [IDX_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = last;
            default: v = IDX_W'($urandom) & last;
        endcase
        return v;
    endfunction

    function automatic t_in_item random_item();
        t_in_item         it;
        logic [IDX_W-1:0] last;
        if ($urandom_range(0, 99) < 12) begin
            // noise: bad faces, deep levels, indices past the span
            it.face      = 3'($urandom);
            it.level     = 5'($urandom);
            it.cell_col  = IDX_W'($urandom);
            it.cell_row  = IDX_W'($urandom);
            it.direction = 2'($urandom);
        end else begin
            it.face  = 3'($urandom_range(0, FACES - 1));
            it.level = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(9, MAX_DEPTH))
                                                   : 5'($urandom_range(0, 8));
            last         = IDX_W'((21'd1 << it.level) - 21'd1);
            it.cell_col  = pick_index(last);
            it.cell_row  = pick_index(last);
            it.direction = 2'($urandom);
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Hold off the sender until every pending neighbor has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        // single-cell face: every edge is a seam
        send_item(mk_item(0, 0, 0, 0, DIR_MINUS_U));
        send_item(mk_item(0, 0, 0, 0, DIR_PLUS_U));
        send_item(mk_item(0, 0, 0, 0, DIR_MINUS_V));
        send_item(mk_item(0, 0, 0, 0, DIR_PLUS_V));
        // seams from the other faces, and one interior step on face 5
        send_item(mk_item(1, 2, 0, 1, DIR_MINUS_U));
        send_item(mk_item(2, 2, 3, 2, DIR_PLUS_U));
        send_item(mk_item(3, 2, 1, 0, DIR_MINUS_V));
        send_item(mk_item(4, 2, 2, 3, DIR_PLUS_V));
        send_item(mk_item(5, 2, 0, 3, DIR_MINUS_V));
        // invalid faces and too-deep levels
        send_item(mk_item(6, 3, 1, 1, DIR_PLUS_U));
        send_item(mk_item(7, 3, 1, 1, DIR_MINUS_V));
        send_item(mk_item(2, MAX_DEPTH + 1, 5, 5, DIR_PLUS_V));
        send_item(mk_item(4, 31, 'hFFFFF, 'hFFFFF, DIR_MINUS_U));
        // widest grid, both corners
        send_item(mk_item(5, MAX_DEPTH, 'hFFFFF, 'hFFFFF, DIR_PLUS_U));
        send_item(mk_item(1, MAX_DEPTH, 'hFFFFF, 'hFFFFF, DIR_MINUS_U));
        send_item(mk_item(3, MAX_DEPTH, 0, 0, DIR_MINUS_V));
        // indices past the span clamp first
        send_item(mk_item(0, 3, 'hFFFFF, 5, DIR_MINUS_U));
        send_item(mk_item(2, 3, 4, 'hABCDE, DIR_PLUS_V));
        // interior steps
        send_item(mk_item(4, 5, 10, 10, DIR_MINUS_U));
        send_item(mk_item(4, 5, 10, 10, DIR_PLUS_U));
        send_item(mk_item(4, 5, 10, 10, DIR_MINUS_V));
        send_item(mk_item(4, 5, 10, 10, DIR_PLUS_V));
    endtask

    initial begin
        int sent;
        int burst;
        int gap;
        int next_drain;
        sb = new;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_for_results();

        sent       = 0;
        next_drain = DRAIN_EVERY;
        while (sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                send_item(random_item());
                sent++;
            end
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            if (sent >= next_drain) begin
                wait_for_results();
                next_drain += DRAIN_EVERY;
            end
        end

        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS cube_chunk_neighbor");
        else
            $display("FAIL cube_chunk_neighbor");
        $finish;
    end

endmodule
